// ----- sv/fmcl_pkg.sv -----
// ----------------------------------------------------------------------------
// fmcl_pkg
// Shared types and constants of the frame marker and checksum learner.
// ----------------------------------------------------------------------------
package fmcl_pkg;

  localparam int MaxFrameLen    = 64;
  localparam int MinFrameLen    = 3;
  localparam int HistCountWidth = 16;
  localparam int PosWidth       = $clog2(MaxFrameLen + 2);

  localparam logic [HistCountWidth-1:0] HistMax = {HistCountWidth{1'b1}};

  localparam logic [7:0] StartMarkerReset = 8'hF7;
  localparam logic [7:0] EndMarkerReset   = 8'hEE;
  localparam logic [7:0] CrcPoly          = 8'h31;

  localparam logic [1:0] RegUnlockLimit = 2'd0;
  localparam logic [1:0] RegLockRun     = 2'd1;
  localparam logic [1:0] RegMarkerMin   = 2'd2;

  localparam logic [2:0] KindNone   = 3'd0;
  localparam logic [2:0] KindXorAll = 3'd1;
  localparam logic [2:0] KindXorTl  = 3'd2;
  localparam logic [2:0] KindSumAll = 3'd3;
  localparam logic [2:0] KindSumTl  = 3'd4;
  localparam logic [2:0] KindNegTl  = 3'd5;
  localparam logic [2:0] KindInvAll = 3'd6;
  localparam logic [2:0] KindCrc    = 3'd7;

  typedef struct packed {
    logic [7:0] x_all;
    logic [7:0] x_tl;
    logic [7:0] s_all;
    logic [7:0] s_tl;
    logic [7:0] crc;
  } sums_t;

  // frame record from the frame front end to the learner core
  typedef struct packed {
    logic [7:0] stx;
    logic [7:0] etx;
    logic [7:0] cs;
    sums_t      sums;
  } frame_t;

  function automatic logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ((r << 1) ^ CrcPoly) : (r << 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] checksum_of(sums_t s, logic [2:0] kind);
    logic [7:0] r;
    unique case (kind)
      KindXorAll: r = s.x_all;
      KindXorTl:  r = s.x_tl;
      KindSumAll: r = s.s_all;
      KindSumTl:  r = s.s_tl;
      KindNegTl:  r = 8'd0 - s.s_tl;
      KindInvAll: r = ~s.s_all;
      KindCrc:    r = s.crc;
      default:    r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/frame_marker_checksum_learner_core.sv -----
// ----------------------------------------------------------------------------
// frame_marker_checksum_learner_core
// Learns a frame's checksum kind and start and end markers, then checks.
// ----------------------------------------------------------------------------
// Input channel: one byte per transaction, in_frame_last on the final byte.
// Output channel: one result transaction per frame of 3 to 64 bytes; other
// frames give none. cfg_ carries register writes (index 0..2); the user is to
// write only while idle, which the block itself does not enforce. A non-final
// byte is accepted whenever the core is idle with no result pending. After a
// final byte both histogram memories are bumped; while unlocked a full scan of
// their 256 entries (registered read) for the maximum follows before the
// result is registered. An unlock adds a clearing sweep of both memories.
// After reset a clearing sweep runs, during which no byte is accepted;
// config writes are always taken. The result sits in an output register;
// while the receiver stalls it holds and no byte is accepted until the result
// transaction completes; the next byte can follow in the cycle after that.
// ----------------------------------------------------------------------------
module frame_marker_checksum_learner_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_locked_now,
  output logic        out_frame_matched,
  output logic [2:0]  out_checksum_kind,
  output logic [7:0]  out_start_marker,
  output logic [7:0]  out_end_marker,
  output logic        out_lock_event,
  output logic        out_unlock_event,
  output logic [31:0] out_frames_tested,
  output logic [31:0] out_frames_matched,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [4:0] {
    C_INIT  = 5'b00001,
    C_IDLE  = 5'b00010,
    C_HIST  = 5'b00100,
    C_CLEAR = 5'b01000,
    C_OUT   = 5'b10000
  } cstate_t;

  cstate_t st_r;
  logic [3:0]  lim_r;
  logic [7:0]  run_len_r;
  logic [15:0] mmin_r;
  logic        lock_r;
  logic [7:0]  ls_r, le_r;
  logic [2:0]  lk_r, cand_r, kind_out_r;
  logic [7:0]  mrun_r;
  logic [3:0]  mis_r;
  logic [31:0] tested_r, matched_r;
  logic        ok_r, lev_r, uev_r;
  fmcl_pkg::frame_t fr_r;
  logic        ov_r;

  logic byte_en, frame_en;
  fmcl_pkg::frame_t frame;
  logic h_busy, h_done, h_clear, h_bump;
  logic [7:0] best_s, best_e;
  logic [fmcl_pkg::HistCountWidth-1:0] max_s, max_e;
  logic [2:0] found;

  assign in_ready  = (st_r == C_IDLE) && !ov_r;
  assign byte_en   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  fmcl_front u_front (
    .clk, .rst_n, .byte_en,
    .data_byte(in_data_byte), .frame_last(in_frame_last),
    .frame_en, .frame
  );

  assign h_bump  = frame_en;
  assign h_clear = (st_r == C_INIT && !h_busy) ||
                   (st_r == C_CLEAR && !h_busy);

  fmcl_hist u_hist (
    .clk, .rst_n, .bump_en(h_bump), .stx(frame.stx), .etx(frame.etx),
    .scan_en(!lock_r), .clear_en(h_clear), .busy(h_busy), .done(h_done),
    .best_s, .best_e, .max_s, .max_e
  );

  always_comb begin
    found = fmcl_pkg::KindNone;
    for (int k = 7; k >= 1; k--) begin
      if (fmcl_pkg::checksum_of(fr_r.sums, 3'(k)) == fr_r.cs) found = 3'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (frame_en) fr_r <= frame;
    if (!rst_n) begin
      st_r <= C_INIT;
      lim_r <= 4'd5; run_len_r <= 8'd10; mmin_r <= 16'd5;
      lock_r <= 1'b0; ls_r <= fmcl_pkg::StartMarkerReset;
      le_r <= fmcl_pkg::EndMarkerReset; lk_r <= fmcl_pkg::KindXorAll;
      cand_r <= fmcl_pkg::KindNone; mrun_r <= '0; mis_r <= '0;
      tested_r <= '0; matched_r <= '0; ov_r <= 1'b0;
      ok_r <= 1'b0; lev_r <= 1'b0; uev_r <= 1'b0; kind_out_r <= '0;
    end else begin
      if (cfg_valid) begin
        priority case (cfg_index)
          fmcl_pkg::RegUnlockLimit: lim_r     <= cfg_data[3:0];
          fmcl_pkg::RegLockRun:     run_len_r <= cfg_data[7:0];
          fmcl_pkg::RegMarkerMin:   mmin_r    <= cfg_data;
          default: ;
        endcase
      end
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (st_r)
        C_INIT: begin
          if (h_done) st_r <= C_IDLE;
        end
        C_IDLE: begin
          if (frame_en) st_r <= C_HIST;
        end
        C_HIST: begin
          if (h_done) begin
            tested_r <= tested_r + 1'b1;
            ok_r <= 1'b0; lev_r <= 1'b0; uev_r <= 1'b0;
            st_r <= C_OUT;
            if (lock_r) begin
              kind_out_r <= lk_r;
              if (fr_r.stx == ls_r && fr_r.etx == le_r &&
                  fmcl_pkg::checksum_of(fr_r.sums, lk_r) == fr_r.cs) begin
                matched_r <= matched_r + 1'b1; mis_r <= '0; ok_r <= 1'b1;
              end else if (((mis_r == 4'hF) ? mis_r : mis_r + 1'b1) >= lim_r) begin
                lock_r <= 1'b0; uev_r <= 1'b1; matched_r <= '0;
                mrun_r <= '0; mis_r <= '0; cand_r <= fmcl_pkg::KindNone;
                kind_out_r <= fmcl_pkg::KindNone;
                st_r <= C_CLEAR;
              end else begin
                mis_r <= (mis_r == 4'hF) ? mis_r : mis_r + 1'b1;
              end
            end else begin
              kind_out_r <= found;
              if (found != fmcl_pkg::KindNone) begin
                ok_r <= 1'b1;
                if (found == cand_r) begin
                  mrun_r <= (mrun_r == 8'hFF) ? mrun_r : mrun_r + 1'b1;
                  if (((mrun_r == 8'hFF) ? mrun_r : mrun_r + 1'b1) >= run_len_r &&
                      max_s >= mmin_r && max_e >= mmin_r) begin
                    lock_r <= 1'b1; lev_r <= 1'b1; ls_r <= best_s; le_r <= best_e;
                    lk_r <= found; matched_r <= tested_r + 1'b1; mis_r <= '0;
                  end
                end else begin
                  cand_r <= found; mrun_r <= 8'd1;
                end
              end
            end
          end
        end
        C_CLEAR: begin
          if (h_done) st_r <= C_OUT;
        end
        C_OUT: begin
          if (!ov_r) begin ov_r <= 1'b1; st_r <= C_IDLE; end
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

  assign out_valid          = ov_r;
  assign out_is_locked_now  = lock_r;
  assign out_frame_matched  = ok_r;
  assign out_checksum_kind  = kind_out_r;
  assign out_start_marker   = ls_r;
  assign out_end_marker     = le_r;
  assign out_lock_event     = lev_r;
  assign out_unlock_event   = uev_r;
  assign out_frames_tested  = tested_r;
  assign out_frames_matched = matched_r;

endmodule

// ----- sv/fmcl_front.sv -----
// ----------------------------------------------------------------------------
// fmcl_front
// Byte intake: position count, tail delay line and running checksums.
// ----------------------------------------------------------------------------
module fmcl_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_en,
  input  logic [7:0]          data_byte,
  input  logic                frame_last,
  output logic                frame_en,
  output fmcl_pkg::frame_t    frame
);

  logic [fmcl_pkg::PosWidth-1:0] pos_r, pos_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] td0_r, td0_nxt, td1_r, td1_nxt;
  fmcl_pkg::sums_t sums_r, sums_nxt, folded;
  logic len_ok;

  always_comb begin
    folded = sums_r;
    if (pos_r >= fmcl_pkg::PosWidth'(2)) begin
      folded.x_all = sums_r.x_all ^ td1_r;
      folded.s_all = sums_r.s_all + td1_r;
      if (pos_r != fmcl_pkg::PosWidth'(2)) begin
        folded.x_tl = sums_r.x_tl ^ td1_r;
        folded.s_tl = sums_r.s_tl + td1_r;
      end
      folded.crc = fmcl_pkg::crc_step(sums_r.crc, td1_r);
    end
    len_ok = (pos_r >= fmcl_pkg::PosWidth'(fmcl_pkg::MinFrameLen - 1)) &&
             (pos_r <= fmcl_pkg::PosWidth'(fmcl_pkg::MaxFrameLen - 1));
    frame_en   = byte_en && frame_last && len_ok;
    frame.stx  = (pos_r == '0) ? data_byte : first_r;
    frame.etx  = data_byte;
    frame.cs   = td0_r;
    frame.sums = folded;

    pos_nxt = pos_r; first_nxt = first_r; td0_nxt = td0_r; td1_nxt = td1_r;
    sums_nxt = sums_r;
    if (byte_en) begin
      if (frame_last) begin
        pos_nxt = '0; first_nxt = '0; td0_nxt = '0; td1_nxt = '0; sums_nxt = '0;
      end else begin
        if (pos_r == '0) first_nxt = data_byte;
        td1_nxt = td0_r;
        td0_nxt = data_byte;
        sums_nxt = folded;
        if (pos_r < fmcl_pkg::PosWidth'(fmcl_pkg::MaxFrameLen + 1)) begin
          pos_nxt = pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; first_r <= '0; td0_r <= '0; td1_r <= '0; sums_r <= '0;
    end else begin
      pos_r <= pos_nxt; first_r <= first_nxt; td0_r <= td0_nxt;
      td1_r <= td1_nxt; sums_r <= sums_nxt;
    end
  end

endmodule

// ----- sv/fmcl_hist.sv -----
// ----------------------------------------------------------------------------
// fmcl_hist
// Start and end histogram memories: bump, full scan for the maximum, clear.
// ----------------------------------------------------------------------------
module fmcl_hist (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        bump_en,
  input  logic [7:0]  stx,
  input  logic [7:0]  etx,
  input  logic        scan_en,
  input  logic        clear_en,
  output logic        busy,
  output logic        done,
  output logic [7:0]  best_s,
  output logic [7:0]  best_e,
  output logic [fmcl_pkg::HistCountWidth-1:0] max_s,
  output logic [fmcl_pkg::HistCountWidth-1:0] max_e
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_BRD   = 6'b000010,
    ST_BWR   = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_CLEAR = 6'b010000,
    ST_DONE  = 6'b100000
  } hstate_t;

  localparam int W = fmcl_pkg::HistCountWidth;

  logic [W-1:0] smem [256];
  logic [W-1:0] emem [256];
  logic [W-1:0] srd_r, erd_r;

  hstate_t st_r, st_nxt;
  logic [8:0] idx_r, idx_nxt;
  logic [7:0] rs_r, re_r;
  logic       scan_r, scan_nxt;
  logic       rv_r;
  logic [7:0] rva_r;
  logic [7:0] bs_r, bs_nxt, be_r, be_nxt;
  logic [W-1:0] ms_r, ms_nxt, me_r, me_nxt;

  logic       we;
  logic [7:0] wa_s, wa_e, ra_s, ra_e;
  logic [W-1:0] wd_s, wd_e;
  logic       re_on;

  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; scan_nxt = scan_r;
    bs_nxt = bs_r; be_nxt = be_r; ms_nxt = ms_r; me_nxt = me_r;
    we = 1'b0; wa_s = rs_r; wa_e = re_r; wd_s = srd_r; wd_e = erd_r;
    ra_s = stx; ra_e = etx; re_on = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (clear_en) begin
          st_nxt = ST_CLEAR; idx_nxt = '0;
        end else if (bump_en) begin
          re_on = 1'b1; scan_nxt = scan_en; st_nxt = ST_BRD;
        end
      end
      ST_BRD: st_nxt = ST_BWR;
      ST_BWR: begin
        we = 1'b1;
        if (srd_r != fmcl_pkg::HistMax) wd_s = srd_r + 1'b1;
        if (erd_r != fmcl_pkg::HistMax) wd_e = erd_r + 1'b1;
        if (scan_r) begin
          st_nxt = ST_SCAN; idx_nxt = '0;
          bs_nxt = fmcl_pkg::StartMarkerReset; be_nxt = fmcl_pkg::EndMarkerReset;
          ms_nxt = '0; me_nxt = '0;
        end else begin
          st_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        ra_s = idx_r[7:0]; ra_e = idx_r[7:0];
        re_on = !idx_r[8];
        if (rv_r) begin
          if (srd_r > ms_r) begin ms_nxt = srd_r; bs_nxt = rva_r; end
          if (erd_r > me_r) begin me_nxt = erd_r; be_nxt = rva_r; end
        end
        if (idx_r[8] && !rv_r) st_nxt = ST_DONE;
        else if (!idx_r[8]) idx_nxt = idx_r + 1'b1;
      end
      ST_CLEAR: begin
        we = 1'b1; wa_s = idx_r[7:0]; wa_e = idx_r[7:0]; wd_s = '0; wd_e = '0;
        idx_nxt = idx_r + 1'b1;
        if (idx_r[7:0] == 8'hFF) st_nxt = ST_DONE;
      end
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (re_on) begin
      srd_r <= smem[ra_s];
      erd_r <= emem[ra_e];
    end
    if (we) begin
      smem[wa_s] <= wd_s;
      emem[wa_e] <= wd_e;
    end
  end

  always_ff @(posedge clk) begin
    rva_r <= idx_r[7:0];
    if (st_r == ST_IDLE) begin rs_r <= stx; re_r <= etx; end
    bs_r <= bs_nxt; be_r <= be_nxt; ms_r <= ms_nxt; me_r <= me_nxt;
    if (!rst_n) begin
      st_r <= ST_IDLE; idx_r <= '0; scan_r <= 1'b0; rv_r <= 1'b0;
    end else begin
      st_r <= st_nxt; idx_r <= idx_nxt; scan_r <= scan_nxt;
      rv_r <= (st_r == ST_SCAN) && re_on;
    end
  end

  assign busy   = (st_r != ST_IDLE);
  assign done   = (st_r == ST_DONE);
  assign best_s = bs_r;
  assign best_e = be_r;
  assign max_s  = ms_r;
  assign max_e  = me_r;

endmodule

// ----- sv/fmcl_checker.sv -----
// ----------------------------------------------------------------------------
// fmcl_checker
// Port-level checks on the learner's result channel.
// ----------------------------------------------------------------------------
module fmcl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_is_locked_now,
  input logic        out_lock_event,
  input logic        out_unlock_event,
  input logic [31:0] out_frames_tested
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frames_tested))
    else $error("result changed while stalled");

  a_lock_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lock_event |-> out_is_locked_now)
    else $error("lock event while unlocked");

  a_unlock_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unlock_event |-> !out_is_locked_now && !out_lock_event)
    else $error("unlock event while locked");

endmodule

bind frame_marker_checksum_learner_core fmcl_checker u_fmcl_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_is_locked_now,
  .out_lock_event, .out_unlock_event, .out_frames_tested
);
